/* rtl/gdfs_pkg.sv */
// Shared types and constants of the grid depth-first path search block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package gdfs_pkg;

  localparam int CW    = 6;        // width of a column or row coordinate
  localparam int LINW  = 2 * CW;   // width of a row times width product
  localparam int CFGW  = 6;        // configuration data width
  localparam int CFGAW = 3;        // configuration index width
  localparam int IDXW  = 10;       // input cell index width
  localparam int CODEW = 3;        // cell code width

  localparam logic [CW-1:0]    GW_RESET      = 6'd32;
  localparam logic [CW-1:0]    GH_RESET      = 6'd32;
  localparam logic [CODEW-1:0] CODE_PATH     = 3'd4;
  localparam logic [CODEW-1:0] CODE_GOAL     = 3'd1;
  localparam logic [CODEW-1:0] CODE_START    = 3'd2;
  localparam logic [CODEW-1:0] CODE_OPEN_MAX = 3'd2;
  localparam logic [CODEW-1:0] CODE_CLEARED  = 3'd0;

  localparam logic [CFGAW-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFGAW-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFGAW-1:0] CFG_START_X     = 3'd2;
  localparam logic [CFGAW-1:0] CFG_START_Y     = 3'd3;
  localparam logic [CFGAW-1:0] CFG_GOAL_X      = 3'd4;
  localparam logic [CFGAW-1:0] CFG_GOAL_Y      = 3'd5;

  typedef enum logic [1:0] {
    MODE_LOAD, MODE_SEARCH, MODE_READ, MODE_CLEAR
  } mode_t;

  typedef enum logic [1:0] {DIR_W, DIR_S, DIR_E, DIR_N} dir_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VCLR, ST_SEED, ST_POP, ST_POP_WT, ST_NB_RD, ST_NB_CHK,
    ST_TR_CHK, ST_TR_WT, ST_TR_GOAL, ST_TR_START, ST_CLR, ST_CLR_END, ST_DONE
  } state_t;

  typedef struct packed {
    logic accept_load;
    logic accept_read;
    logic begin_search;
    logic begin_clear;
    logic vclr_step;
    logic seed;
    logic pop_rd;
    logic pop_take;
    logic nb_rd;
    logic nb_chk;
    logic tr_begin;
    logic tr_mark;
    logic tr_take;
    logic tr_goal;
    logic tr_start;
    logic clr_step;
    logic clr_tail;
    logic out_strobe;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic dims_bad;
    logic stack_empty;
    logic cur_is_goal;
    logic last_dir;
    logic p_is_start;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/gdfs_ctrl.sv */
// Controller state machine of the grid search: sequences loads, reads, searches and clears.
// Depends on gdfs_pkg; drives the datapath through cmd_t and watches sts_t.
`default_nettype none

module gdfs_ctrl import gdfs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_mode,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic            busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (mode_t'(in_mode))
            MODE_SEARCH: state_nxt = ST_VCLR;
            MODE_CLEAR:  state_nxt = ST_CLR;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_VCLR:     if (sts.sweep_last) state_nxt = sts.dims_bad ? ST_DONE : ST_SEED;
      ST_SEED:     state_nxt = ST_POP;
      ST_POP:      state_nxt = sts.stack_empty ? ST_DONE : ST_POP_WT;
      ST_POP_WT:   state_nxt = sts.cur_is_goal ? ST_TR_CHK : ST_NB_RD;
      ST_NB_RD:    state_nxt = ST_NB_CHK;
      ST_NB_CHK:   state_nxt = sts.last_dir ? ST_POP : ST_NB_RD;
      ST_TR_CHK:   state_nxt = sts.p_is_start ? ST_TR_GOAL : ST_TR_WT;
      ST_TR_WT:    state_nxt = ST_TR_CHK;
      ST_TR_GOAL:  state_nxt = ST_TR_START;
      ST_TR_START: state_nxt = ST_IDLE;
      ST_CLR:      if (sts.sweep_last) state_nxt = ST_CLR_END;
      ST_CLR_END:  state_nxt = ST_IDLE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (mode_t'(in_mode))
            MODE_LOAD: begin
              cmd.accept_load = 1'b1;
              cmd.out_strobe  = 1'b1;
            end
            MODE_READ: begin
              cmd.accept_read = 1'b1;
              cmd.out_strobe  = 1'b1;
            end
            MODE_SEARCH: cmd.begin_search = 1'b1;
            MODE_CLEAR:  cmd.begin_clear  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_VCLR:   cmd.vclr_step = 1'b1;
      ST_SEED:   cmd.seed = 1'b1;
      ST_POP:    cmd.pop_rd = !sts.stack_empty;
      ST_POP_WT: begin
        cmd.tr_begin = sts.cur_is_goal;
        cmd.pop_take = !sts.cur_is_goal;
      end
      ST_NB_RD:  cmd.nb_rd = 1'b1;
      ST_NB_CHK: cmd.nb_chk = 1'b1;
      ST_TR_CHK: cmd.tr_mark = !sts.p_is_start;
      ST_TR_WT:  cmd.tr_take = 1'b1;
      ST_TR_GOAL: cmd.tr_goal = 1'b1;
      ST_TR_START: begin
        cmd.tr_start   = 1'b1;
        cmd.out_strobe = 1'b1;
      end
      ST_CLR:    cmd.clr_step = 1'b1;
      ST_CLR_END: begin
        cmd.clr_tail   = 1'b1;
        cmd.out_strobe = 1'b1;
      end
      ST_DONE:   cmd.out_strobe = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/gdfs_datapath.sv */
// Datapath of the grid search: configuration registers, cell, visited, parent and stack
// memories, neighbor generation and path trace. Depends on gdfs_pkg; driven by gdfs_ctrl.
`default_nettype none

module gdfs_datapath import gdfs_pkg::*; #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDXW-1:0]  in_cell_index,
  input  wire logic [CODEW-1:0] in_cell_code,
  input  wire logic             cfg_we,
  input  wire logic [CFGAW-1:0] cfg_index,
  input  wire logic [CFGW-1:0]  cfg_wdata,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  output logic [CODEW-1:0]      out_read_code,
  output logic                  out_path_found
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int SW    = AW + 2 * CW;

  // Configuration registers.
  logic [CW-1:0]   gw_r, gh_r;
  logic [CW-2:0]   sx_r, sy_r, gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_RESET;
      gh_r <= GH_RESET;
      sx_r <= '0;
      sy_r <= '0;
      gx_r <= '0;
      gy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  gw_r <= cfg_wdata;
        CFG_GRID_HEIGHT: gh_r <= cfg_wdata;
        CFG_START_X:     sx_r <= cfg_wdata[CW-2:0];
        CFG_START_Y:     sy_r <= cfg_wdata[CW-2:0];
        CFG_GOAL_X:      gx_r <= cfg_wdata[CW-2:0];
        CFG_GOAL_Y:      gy_r <= cfg_wdata[CW-2:0];
        default: ;
      endcase
    end
  end

  // Grid size in use; zero counts as one, oversize counts as the maximum.
  logic [CW-1:0] w_c, h_c;
  always_comb begin
    w_c = gw_r;
    if (gw_r == '0) w_c = CW'(1);
    else if (32'(gw_r) > MAX_COLUMNS) w_c = CW'(MAX_COLUMNS);
    h_c = gh_r;
    if (gh_r == '0) h_c = CW'(1);
    else if (32'(gh_r) > MAX_ROWS) h_c = CW'(MAX_ROWS);
  end

  logic [LINW-1:0] s_lin, g_lin;
  assign s_lin = LINW'(sy_r) * LINW'(w_c) + LINW'(sx_r);
  assign g_lin = LINW'(gy_r) * LINW'(w_c) + LINW'(gx_r);

  // Registers of the walk.
  logic [AW-1:0]   s_idx_r, g_idx_r, p_r, cnt_r, clr_prev_r;
  logic [CW-1:0]   s_x_r, s_y_r;
  logic [AW-1:0]   cur_idx_r, nb_idx_r;
  logic [CW-1:0]   cur_x_r, cur_y_r, nb_x_r, nb_y_r;
  logic            nb_in_r;
  dir_t            dir_r;
  logic [DW-1:0]   sp_r;
  logic            found_r, clr_pend_r, out_valid_r, rd_sel_r;

  logic [CODEW-1:0] cell_q;
  logic             vis_q;
  logic [AW-1:0]    par_q;
  logic [SW-1:0]    stk_q;

  // Neighbor in the current direction.
  logic          nb_in;
  logic [AW-1:0] nb_idx;
  logic [CW-1:0] nb_x, nb_y;
  always_comb begin
    nb_in  = 1'b0;
    nb_idx = cur_idx_r;
    nb_x   = cur_x_r;
    nb_y   = cur_y_r;
    unique case (dir_r)
      DIR_W: begin
        nb_in  = (cur_x_r != '0);
        nb_idx = cur_idx_r - AW'(1);
        nb_x   = cur_x_r - CW'(1);
      end
      DIR_S: begin
        nb_in  = ({1'b0, cur_y_r} + (CW+1)'(1)) < {1'b0, h_c};
        nb_idx = cur_idx_r + AW'(w_c);
        nb_y   = cur_y_r + CW'(1);
      end
      DIR_E: begin
        nb_in  = ({1'b0, cur_x_r} + (CW+1)'(1)) < {1'b0, w_c};
        nb_idx = cur_idx_r + AW'(1);
        nb_x   = cur_x_r + CW'(1);
      end
      DIR_N: begin
        nb_in  = (cur_y_r != '0);
        nb_idx = cur_idx_r - AW'(w_c);
        nb_y   = cur_y_r - CW'(1);
      end
      default: ;
    endcase
  end

  logic in_ok, push;
  assign in_ok = (32'(in_cell_index) < CELLS);
  assign push  = cmd.nb_chk && nb_in_r && (cell_q <= CODE_OPEN_MAX) && !vis_q;

  logic [DW-1:0] sp_dec;
  assign sp_dec = sp_r - DW'(1);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      found_r     <= 1'b0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
      cnt_r       <= '0;
      dir_r       <= DIR_W;
    end else begin
      out_valid_r <= cmd.out_strobe;
      rd_sel_r    <= cmd.accept_read && in_ok;
      if (cmd.begin_search || cmd.begin_clear) cnt_r <= '0;
      else if (cmd.vclr_step || cmd.clr_step) cnt_r <= cnt_r + AW'(1);
      if (cmd.begin_search) sp_r <= '0;
      else if (cmd.seed) sp_r <= DW'(1);
      else if (cmd.pop_rd) sp_r <= sp_dec;
      else if (push) sp_r <= sp_r + DW'(1);
      if (cmd.begin_search) found_r <= 1'b0;
      else if (cmd.tr_start) found_r <= 1'b1;
      if (cmd.begin_clear) clr_pend_r <= 1'b0;
      else if (cmd.clr_step) clr_pend_r <= 1'b1;
      if (cmd.pop_take) dir_r <= DIR_W;
      else if (cmd.nb_chk) dir_r <= dir_t'(dir_r + 2'd1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.begin_search) begin
      s_idx_r <= AW'(s_lin);
      g_idx_r <= AW'(g_lin);
      s_x_r   <= CW'(sx_r);
      s_y_r   <= CW'(sy_r);
    end
    if (cmd.pop_take) begin
      {cur_idx_r, cur_x_r, cur_y_r} <= stk_q;
    end
    if (cmd.nb_rd) begin
      nb_in_r  <= nb_in;
      nb_idx_r <= nb_idx;
      nb_x_r   <= nb_x;
      nb_y_r   <= nb_y;
    end
    if (cmd.tr_begin) p_r <= g_idx_r;
    else if (cmd.tr_take) p_r <= par_q;
    if (cmd.clr_step) clr_prev_r <= cnt_r;
  end

  // Cell store: one write port, one registered read port.
  logic [CODEW-1:0] cell_mem [CELLS];
  logic             cell_we;
  logic [AW-1:0]    cell_wa, cell_ra;
  logic [CODEW-1:0] cell_wd;

  always_comb begin
    cell_we = 1'b0;
    cell_wa = p_r;
    cell_wd = CODE_PATH;
    priority if (cmd.accept_load) begin
      cell_we = in_ok;
      cell_wa = AW'(in_cell_index);
      cell_wd = in_cell_code;
    end else if (cmd.tr_mark) begin
      cell_we = 1'b1;
    end else if (cmd.tr_goal) begin
      cell_we = 1'b1;
      cell_wa = g_idx_r;
      cell_wd = CODE_GOAL;
    end else if (cmd.tr_start) begin
      cell_we = 1'b1;
      cell_wa = s_idx_r;
      cell_wd = CODE_START;
    end else if (cmd.clr_step || cmd.clr_tail) begin
      // The read of the previous sweep address has just come back.
      cell_we = clr_pend_r && (cell_q == CODE_PATH);
      cell_wa = clr_prev_r;
      cell_wd = CODE_CLEARED;
    end
    priority if (cmd.accept_read) cell_ra = AW'(in_cell_index);
    else if (cmd.nb_rd) cell_ra = nb_idx;
    else cell_ra = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_q <= cell_mem[cell_ra];
  end

  // Visited map, cleared by a sweep at the start of every search.
  logic          vis_mem [CELLS];
  logic          vis_we, vis_wd;
  logic [AW-1:0] vis_wa;

  always_comb begin
    vis_we = cmd.vclr_step || cmd.seed || push;
    vis_wd = !cmd.vclr_step;
    priority if (cmd.vclr_step) vis_wa = cnt_r;
    else if (cmd.seed) vis_wa = s_idx_r;
    else vis_wa = nb_idx_r;
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[nb_idx];
  end

  // Parent store and search stack.
  logic [AW-1:0] par_mem [CELLS];
  logic [SW-1:0] stk_mem [CELLS];

  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      par_mem[s_idx_r] <= s_idx_r;
      stk_mem[AW'(0)]  <= {s_idx_r, s_x_r, s_y_r};
    end else if (push) begin
      par_mem[nb_idx_r]      <= cur_idx_r;
      stk_mem[sp_r[AW-1:0]]  <= {nb_idx_r, nb_x_r, nb_y_r};
    end
    par_q <= par_mem[p_r];
    stk_q <= stk_mem[sp_dec[AW-1:0]];
  end

  assign sts.sweep_last  = (cnt_r == AW'(CELLS - 1));
  assign sts.dims_bad    = (CW'(sx_r) >= w_c) || (CW'(sy_r) >= h_c) ||
                           (CW'(gx_r) >= w_c) || (CW'(gy_r) >= h_c);
  assign sts.stack_empty = (sp_r == '0);
  assign sts.cur_is_goal = (stk_q[SW-1:2*CW] == g_idx_r);
  assign sts.last_dir    = (dir_r == DIR_N);
  assign sts.p_is_start  = (p_r == s_idx_r);

  assign out_valid      = out_valid_r;
  assign out_read_code  = rd_sel_r ? cell_q : CODE_CLEARED;
  assign out_path_found = found_r;

endmodule

`default_nettype wire

/* rtl/grid_depth_first_path_search.sv */
// Top level of the grid depth-first path search; joins gdfs_ctrl and gdfs_datapath.
// Depends on gdfs_pkg.
//
// A transaction is taken when start is high and busy is low; its single result shows on
// the out_ ports for one cycle, marked by out_valid, and the receiver cannot stall it.
// Loads and reads never raise busy and may follow back to back; each result shows in the
// next cycle. A search first sweeps the visited map and ends there if the start or goal
// lies outside the grid; it then pops cells and reads and checks the four neighbors of
// each, and on reaching the goal follows the parent links to mark the path. A clear
// sweeps the whole cell store. busy falls in the cycle that shows the result.
`default_nettype none

module grid_depth_first_path_search import gdfs_pkg::*; #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_mode,
  input  wire logic [IDXW-1:0]  in_cell_index,
  input  wire logic [CODEW-1:0] in_cell_code,
  output logic                  out_valid,
  output logic [CODEW-1:0]      out_read_code,
  output logic                  out_path_found,
  input  wire logic             cfg_we,
  input  wire logic [CFGAW-1:0] cfg_index,
  input  wire logic [CFGW-1:0]  cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  gdfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  gdfs_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cell_index  (in_cell_index),
    .in_cell_code   (in_cell_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_read_code  (out_read_code),
    .out_path_found (out_path_found)
  );

endmodule

`default_nettype wire

/* rtl/gdfs_checker.sv */
// Port-level checks of the grid search top level, attached by the bind at the end.
// Depends on gdfs_pkg for the mode codes and the code width.
`default_nettype none

module gdfs_checker import gdfs_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       in_mode,
  input wire logic             out_valid,
  input wire logic [CODEW-1:0] out_read_code
);

  logic take;
  assign take = start && !busy;

  // A result comes only from a transaction just taken or from work that was under way.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(take) || $past(busy)))
    else $error("result without a transaction");

  // Loads and reads answer in the next cycle without going busy.
  a_fast_modes: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_mode == MODE_LOAD || in_mode == MODE_READ)) |=> (out_valid && !busy))
    else $error("load or read did not answer in one cycle");

  // Searches and clears hold the block busy.
  a_long_modes: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_mode == MODE_SEARCH || in_mode == MODE_CLEAR)) |=> (busy && !out_valid))
    else $error("search or clear did not go busy");

  // Every long transaction ends with its result.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // The read code is zero unless a read result is shown.
  a_code_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (out_read_code == '0))
    else $error("read code driven outside a result");

endmodule

bind grid_depth_first_path_search gdfs_checker u_gdfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_read_code (out_read_code)
);

`default_nettype wire
